// ----- hdl/lgrd_pkg.sv -----
// Package for the limited-length Golomb-Rice decoder: widths, limits and beat types.
`timescale 1ns / 1ps

package lgrd_pkg;

  localparam int VALUE_WIDTH = 32;  // result saturates to 2^VALUE_WIDTH-1
  localparam int MAX_ZEROS   = 64;  // zero bound in plain mode

  localparam int ZC_W   = 7;
  localparam int K_W    = 5;
  localparam int ACC_W  = 32;
  localparam int DOUT_W = 32;
  // zero count shifted by up to 31, plus the accumulator, plus a carry
  localparam int SUM_W  = ZC_W + (1 << K_W) + 1;

  localparam logic [SUM_W-1:0] VALUE_MAX = (SUM_W'(1) << VALUE_WIDTH) - SUM_W'(1);

  typedef struct packed {
    logic            code_bit;
    logic            mode;
    logic [K_W-1:0]  rice_k;
    logic [ZC_W-1:0] zero_limit;
    logic [K_W-1:0]  escape_bits;
  } lgrd_in_t;

  typedef struct packed {
    logic [DOUT_W-1:0] decoded_value;
    logic              escaped;
    logic              code_error;
  } lgrd_out_t;

endpackage

// ----- hdl/limited_golomb_rice_decoder_core.sv -----
// Top level: bit-serial limited-length Golomb-Rice decoder with registered result.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_data) carries one code bit per beat,
//   along with mode, rice_k, zero_limit and escape_bits; those four are taken
//   only on the first bit of a codeword and held until its result is out.
//   Output channel (out_valid / out_stall / out_data) carries one decoded value
//   per codeword, with the escape and error flags.
// Throughput: one code bit per clock, sustained, as long as results drain.
//   The decode state (phase, zero count, bits left, accumulator) updates in the
//   same cycle that a bit is accepted.
// Result: registered in the output register, or the skid register on a stall.
// Stall: a result that cannot leave stays in the output register; one more
//   result fits in a skid register, after which in_stall goes high until the
//   output register drains.
// Reset (rst_n low, synchronous): decoder returns to codeword start, both
//   result registers are emptied.
module limited_golomb_rice_decoder_core
  import lgrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lgrd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lgrd_out_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZEROS,
    ST_SUFFIX,
    ST_ESCAPE
  } state_t;

  state_t          phase_r, phase_nxt;
  logic [ZC_W-1:0] zc_r, zc_nxt;
  logic [K_W-1:0]  bl_r, bl_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [K_W-1:0]  held_k_r, held_k_nxt;
  logic [ZC_W-1:0] held_lim_r, held_lim_nxt;
  logic [K_W-1:0]  held_esc_r, held_esc_nxt;
  logic            held_mode_r, held_mode_nxt;

  logic      out_vld_r, out_vld_nxt;
  lgrd_out_t out_r, out_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  lgrd_out_t skid_r, skid_nxt;

  logic            in_fire, start;
  logic            eff_mode;
  logic [K_W-1:0]  eff_k, eff_esc;
  logic [ZC_W-1:0] eff_lim, eff_zc, bound;
  logic [ACC_W-1:0] shift_acc;
  logic [K_W-1:0]  bl_dec;
  logic [SUM_W-1:0] plain_sum, esc_sum, res_sum;
  logic            res_vld, res_esc, res_err, res_sat;
  lgrd_out_t       res;

  assign in_stall  = skid_vld_r;
  assign in_fire   = in_valid && !skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign start    = (phase_r == ST_IDLE);
  assign eff_mode = start ? in_data.mode        : held_mode_r;
  assign eff_k    = start ? in_data.rice_k      : held_k_r;
  assign eff_lim  = start ? in_data.zero_limit  : held_lim_r;
  assign eff_esc  = start ? in_data.escape_bits : held_esc_r;
  assign eff_zc   = start ? '0 : zc_r;
  assign bound    = eff_mode ? eff_lim : ZC_W'(MAX_ZEROS);

  assign shift_acc = {acc_r[ACC_W-2:0], in_data.code_bit};
  assign bl_dec    = bl_r - K_W'(1);

  // suffix comes from the shifted accumulator only on the last suffix bit
  assign plain_sum = (SUM_W'(eff_zc) << eff_k)
                   + ((phase_r == ST_SUFFIX) ? SUM_W'(shift_acc) : '0);
  assign esc_sum   = ((phase_r == ST_ESCAPE) ? SUM_W'(shift_acc) : '0) + SUM_W'(1);

  assign res_sat = (res_sum > VALUE_MAX);
  always_comb begin
    res.decoded_value = res_sat ? VALUE_MAX[DOUT_W-1:0] : res_sum[DOUT_W-1:0];
    res.escaped       = res_esc;
    res.code_error    = res_err | res_sat;
  end

  // decode step for the accepted bit
  always_comb begin
    phase_nxt     = phase_r;
    zc_nxt        = zc_r;
    bl_nxt        = bl_r;
    acc_nxt       = acc_r;
    held_k_nxt    = held_k_r;
    held_lim_nxt  = held_lim_r;
    held_esc_nxt  = held_esc_r;
    held_mode_nxt = held_mode_r;
    res_vld       = 1'b0;
    res_esc       = 1'b0;
    res_err       = 1'b0;
    res_sum       = plain_sum;
    if (in_fire) begin
      unique case (phase_r) inside
        ST_IDLE, ST_ZEROS: begin
          if (start) begin
            held_mode_nxt = in_data.mode;
            held_k_nxt    = in_data.rice_k;
            held_lim_nxt  = in_data.zero_limit;
            held_esc_nxt  = in_data.escape_bits;
          end
          zc_nxt    = eff_zc;
          bl_nxt    = '0;
          acc_nxt   = '0;
          phase_nxt = ST_ZEROS;
          if (!in_data.code_bit) begin
            if (eff_zc >= bound) begin
              // too many zeros: end the codeword with a saturated error
              res_vld = 1'b1;
              res_err = 1'b1;
              res_sum = VALUE_MAX;
            end else begin
              zc_nxt = eff_zc + ZC_W'(1);
            end
          end else if (eff_mode && (eff_zc == eff_lim)) begin
            if (eff_esc == '0) begin
              res_vld = 1'b1;
              res_esc = 1'b1;
              res_sum = esc_sum;
            end else begin
              bl_nxt    = eff_esc;
              phase_nxt = ST_ESCAPE;
            end
          end else if (eff_k == '0) begin
            res_vld = 1'b1;
          end else begin
            bl_nxt    = eff_k;
            phase_nxt = ST_SUFFIX;
          end
        end
        ST_SUFFIX, ST_ESCAPE: begin
          acc_nxt = shift_acc;
          bl_nxt  = bl_dec;
          if (bl_dec == '0) begin
            res_vld = 1'b1;
            if (phase_r == ST_ESCAPE) begin
              res_esc = 1'b1;
              res_sum = esc_sum;
            end
          end
        end
      endcase
      if (res_vld) begin
        phase_nxt = ST_IDLE;
        zc_nxt    = '0;
        bl_nxt    = '0;
        acc_nxt   = '0;
      end
    end
  end

  // output register plus one skid entry
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = res_vld;
        out_nxt     = res;
      end
    end else if (res_vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_IDLE;
      zc_r        <= '0;
      bl_r        <= '0;
      acc_r       <= '0;
      held_k_r    <= '0;
      held_lim_r  <= '0;
      held_esc_r  <= '0;
      held_mode_r <= 1'b0;
      out_vld_r   <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      zc_r        <= zc_nxt;
      bl_r        <= bl_nxt;
      acc_r       <= acc_nxt;
      held_k_r    <= held_k_nxt;
      held_lim_r  <= held_lim_nxt;
      held_esc_r  <= held_esc_nxt;
      held_mode_r <= held_mode_nxt;
      out_vld_r   <= out_vld_nxt;
      skid_vld_r  <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

`ifndef NO_ASSERTIONS
  // skid entry is only ever filled behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a beat while output register is empty");

  // every result closes its codeword
  a_result_ends_code: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> (phase_r == ST_IDLE) && (zc_r == '0) && (acc_r == '0))
    else $error("decoder not back at codeword start after a result");

  // an error result always carries the saturated value
  a_error_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.code_error |-> out_r.decoded_value == VALUE_MAX[DOUT_W-1:0])
    else $error("error result without saturated value");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (phase_r == ST_IDLE) && !out_vld_r && !skid_vld_r)
    else $error("reset did not return decoder to start");
`endif

endmodule
